// ----- rtl/core/msl_pkg.sv -----
`timescale 1ns / 1ps

package msl_pkg;

  localparam int FRAC_BITS = 29;
  localparam int WORK_FRAC = 16;
  localparam int WORK_SH   = FRAC_BITS - WORK_FRAC;
  localparam int WORK_LIM  = 1 << 18;
  localparam int EPS_RAW   = ((1 << FRAC_BITS) + 5000) / 10000;

  localparam logic signed [31:0] WORK_HI = 32'(WORK_LIM - 1);
  localparam logic signed [31:0] WORK_LO = 32'(-WORK_LIM);

  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, 63'd0};
  localparam logic signed [63:0] OUT_HI  = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] OUT_LO  = -(64'sd1 <<< 47);

  localparam int CFG_COUNT = 6;
  localparam int CFG_IDX_W = 3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CENTER = 2'd1;
  localparam logic [1:0] ST_DIPOLE = 2'd2;
  localparam logic [1:0] ST_FNEG   = 2'd3;

  // sequencer opcodes
  localparam logic [3:0] OP_LDW    = 4'd0;
  localparam logic [3:0] OP_LDR    = 4'd1;
  localparam logic [3:0] OP_LDK    = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_SUB    = 4'd4;
  localparam logic [3:0] OP_SATSUB = 4'd5;
  localparam logic [3:0] OP_SATACC = 4'd6;
  localparam logic [3:0] OP_MUL    = 4'd7;
  localparam logic [3:0] OP_MAC    = 4'd8;
  localparam logic [3:0] OP_MSB    = 4'd9;
  localparam logic [3:0] OP_MULDIV = 4'd10;
  localparam logic [3:0] OP_SQRT   = 4'd11;
  localparam logic [3:0] OP_CHKZ   = 4'd12;
  localparam logic [3:0] OP_CHKP   = 4'd13;
  localparam logic [3:0] OP_END    = 4'd14;

  // scratch addresses
  localparam int SCR_DEPTH = 32;
  localparam logic [4:0] A_RX    = 5'd0;
  localparam logic [4:0] A_RY    = 5'd1;
  localparam logic [4:0] A_RZ    = 5'd2;
  localparam logic [4:0] A_P0X   = 5'd3;
  localparam logic [4:0] A_P0Y   = 5'd4;
  localparam logic [4:0] A_P0Z   = 5'd5;
  localparam logic [4:0] A_QX    = 5'd6;
  localparam logic [4:0] A_QY    = 5'd7;
  localparam logic [4:0] A_QZ    = 5'd8;
  localparam logic [4:0] A_OX    = 5'd9;
  localparam logic [4:0] A_OY    = 5'd10;
  localparam logic [4:0] A_OZ    = 5'd11;
  localparam logic [4:0] A_AX    = 5'd12;
  localparam logic [4:0] A_AY    = 5'd13;
  localparam logic [4:0] A_AZ    = 5'd14;
  localparam logic [4:0] A_R     = 5'd15;
  localparam logic [4:0] A_A     = 5'd16;
  localparam logic [4:0] A_R0DOT = 5'd17;
  localparam logic [4:0] A_ARDOT = 5'd18;
  localparam logic [4:0] A_T     = 5'd19;
  localparam logic [4:0] A_F     = 5'd20;
  localparam logic [4:0] A_ALPHA = 5'd21;
  localparam logic [4:0] A_BETA  = 5'd22;
  localparam logic [4:0] A_XX    = 5'd23;
  localparam logic [4:0] A_XY    = 5'd24;
  localparam logic [4:0] A_XZ    = 5'd25;
  localparam logic [4:0] A_S     = 5'd26;
  localparam logic [4:0] A_C     = 5'd27;
  localparam logic [4:0] A_G     = 5'd28;
  localparam logic [4:0] A_K1    = 5'd29;
  localparam logic [4:0] A_TMP   = 5'd30;
  localparam logic [4:0] A_K     = 5'd31;
  localparam logic [4:0] A_NONE  = 5'd0;

  // source words for loads
  localparam logic [3:0] W_PX     = 4'd0;
  localparam logic [3:0] W_PY     = 4'd1;
  localparam logic [3:0] W_PZ     = 4'd2;
  localparam logic [3:0] W_OX     = 4'd3;
  localparam logic [3:0] W_OY     = 4'd4;
  localparam logic [3:0] W_OZ     = 4'd5;
  localparam logic [3:0] W_P0X    = 4'd6;
  localparam logic [3:0] W_P0Y    = 4'd7;
  localparam logic [3:0] W_P0Z    = 4'd8;
  localparam logic [3:0] W_QX     = 4'd9;
  localparam logic [3:0] W_QY     = 4'd10;
  localparam logic [3:0] W_QZ     = 4'd11;
  localparam logic [3:0] W_WEIGHT = 4'd12;
  localparam logic [3:0] W_TURNS  = 4'd13;

  // constants
  localparam logic [3:0] K_ONE  = 4'd0;
  localparam logic [3:0] K_2P16 = 4'd1;
  localparam logic [3:0] K_2P24 = 4'd2;
  localparam logic [3:0] K_2P40 = 4'd3;
  localparam logic [3:0] K_FRAC = 4'd4;

  localparam int PROG_LEN = 82;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] c;
    logic [3:0] arg;
  } instr_t;

  function automatic instr_t mk(input logic [3:0] op, input logic [4:0] dst,
                                input logic [4:0] a, input logic [4:0] b,
                                input logic [4:0] c, input logic [3:0] arg);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.a   = a;
    i.b   = b;
    i.c   = c;
    i.arg = arg;
    return i;
  endfunction

  function automatic logic signed [63:0] kconst(input logic [3:0] k);
    logic signed [63:0] v;
    case (k)
      K_ONE:   v = 64'sd1;
      K_2P16:  v = 64'sd1 <<< 16;
      K_2P24:  v = 64'sd1 <<< 24;
      K_2P40:  v = 64'sd1 <<< 40;
      K_FRAC:  v = 64'sd1 <<< FRAC_BITS;
      default: v = 64'sd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] to_work(input logic signed [31:0] v);
    logic signed [31:0] q;
    q = v >>> WORK_SH;
    if (q > WORK_HI) q = WORK_HI;
    if (q < WORK_LO) q = WORK_LO;
    return 64'(q);
  endfunction

  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      7'd0:  i = mk(OP_LDW, A_RX, A_NONE, A_NONE, A_NONE, W_PX);
      7'd1:  i = mk(OP_LDW, A_RY, A_NONE, A_NONE, A_NONE, W_PY);
      7'd2:  i = mk(OP_LDW, A_RZ, A_NONE, A_NONE, A_NONE, W_PZ);
      7'd3:  i = mk(OP_LDW, A_OX, A_NONE, A_NONE, A_NONE, W_OX);
      7'd4:  i = mk(OP_LDW, A_OY, A_NONE, A_NONE, A_NONE, W_OY);
      7'd5:  i = mk(OP_LDW, A_OZ, A_NONE, A_NONE, A_NONE, W_OZ);
      7'd6:  i = mk(OP_LDW, A_P0X, A_NONE, A_NONE, A_NONE, W_P0X);
      7'd7:  i = mk(OP_LDW, A_P0Y, A_NONE, A_NONE, A_NONE, W_P0Y);
      7'd8:  i = mk(OP_LDW, A_P0Z, A_NONE, A_NONE, A_NONE, W_P0Z);
      7'd9:  i = mk(OP_LDW, A_QX, A_NONE, A_NONE, A_NONE, W_QX);
      7'd10: i = mk(OP_LDW, A_QY, A_NONE, A_NONE, A_NONE, W_QY);
      7'd11: i = mk(OP_LDW, A_QZ, A_NONE, A_NONE, A_NONE, W_QZ);
      7'd12: i = mk(OP_SUB, A_AX, A_RX, A_P0X, A_NONE, K_ONE);
      7'd13: i = mk(OP_SUB, A_AY, A_RY, A_P0Y, A_NONE, K_ONE);
      7'd14: i = mk(OP_SUB, A_AZ, A_RZ, A_P0Z, A_NONE, K_ONE);
      7'd15: i = mk(OP_MUL, A_TMP, A_RX, A_RX, A_NONE, K_ONE);
      7'd16: i = mk(OP_MAC, A_TMP, A_RY, A_RY, A_NONE, K_ONE);
      7'd17: i = mk(OP_MAC, A_TMP, A_RZ, A_RZ, A_NONE, K_ONE);
      7'd18: i = mk(OP_SQRT, A_R, A_TMP, A_NONE, A_NONE, K_ONE);
      7'd19: i = mk(OP_CHKZ, A_NONE, A_R, A_NONE, A_NONE, 4'(ST_CENTER));
      7'd20: i = mk(OP_MUL, A_TMP, A_AX, A_AX, A_NONE, K_ONE);
      7'd21: i = mk(OP_MAC, A_TMP, A_AY, A_AY, A_NONE, K_ONE);
      7'd22: i = mk(OP_MAC, A_TMP, A_AZ, A_AZ, A_NONE, K_ONE);
      7'd23: i = mk(OP_SQRT, A_A, A_TMP, A_NONE, A_NONE, K_ONE);
      7'd24: i = mk(OP_CHKZ, A_NONE, A_A, A_NONE, A_NONE, 4'(ST_DIPOLE));
      7'd25: i = mk(OP_MUL, A_R0DOT, A_P0X, A_RX, A_NONE, K_ONE);
      7'd26: i = mk(OP_MAC, A_R0DOT, A_P0Y, A_RY, A_NONE, K_ONE);
      7'd27: i = mk(OP_MAC, A_R0DOT, A_P0Z, A_RZ, A_NONE, K_ONE);
      7'd28: i = mk(OP_MUL, A_ARDOT, A_AX, A_RX, A_NONE, K_ONE);
      7'd29: i = mk(OP_MAC, A_ARDOT, A_AY, A_RY, A_NONE, K_ONE);
      7'd30: i = mk(OP_MAC, A_ARDOT, A_AZ, A_RZ, A_NONE, K_ONE);
      7'd31: i = mk(OP_MUL, A_T, A_R, A_A, A_NONE, K_ONE);
      7'd32: i = mk(OP_MAC, A_T, A_R, A_R, A_NONE, K_ONE);
      7'd33: i = mk(OP_SUB, A_T, A_T, A_R0DOT, A_NONE, K_ONE);
      7'd34: i = mk(OP_MUL, A_F, A_A, A_T, A_NONE, K_ONE);
      7'd35: i = mk(OP_CHKP, A_NONE, A_F, A_NONE, A_NONE, 4'(ST_FNEG));
      7'd36: i = mk(OP_LDK, A_K1, A_NONE, A_NONE, A_NONE, K_ONE);
      7'd37: i = mk(OP_MULDIV, A_TMP, A_ARDOT, A_K1, A_A, K_ONE);
      7'd38: i = mk(OP_ADD, A_BETA, A_A, A_R, A_NONE, K_ONE);
      7'd39: i = mk(OP_ADD, A_BETA, A_BETA, A_R, A_NONE, K_ONE);
      7'd40: i = mk(OP_ADD, A_BETA, A_BETA, A_TMP, A_NONE, K_ONE);
      7'd41: i = mk(OP_MULDIV, A_ALPHA, A_A, A_A, A_R, K_ONE);
      7'd42: i = mk(OP_ADD, A_ALPHA, A_ALPHA, A_BETA, A_NONE, K_ONE);
      7'd43: i = mk(OP_ADD, A_ALPHA, A_ALPHA, A_A, A_NONE, K_ONE);
      7'd44: i = mk(OP_MUL, A_XX, A_QY, A_P0Z, A_NONE, K_ONE);
      7'd45: i = mk(OP_MSB, A_XX, A_QZ, A_P0Y, A_NONE, K_ONE);
      7'd46: i = mk(OP_MUL, A_XY, A_QZ, A_P0X, A_NONE, K_ONE);
      7'd47: i = mk(OP_MSB, A_XY, A_QX, A_P0Z, A_NONE, K_ONE);
      7'd48: i = mk(OP_MUL, A_XZ, A_QX, A_P0Y, A_NONE, K_ONE);
      7'd49: i = mk(OP_MSB, A_XZ, A_QY, A_P0X, A_NONE, K_ONE);
      7'd50: i = mk(OP_MUL, A_S, A_XX, A_OX, A_NONE, K_ONE);
      7'd51: i = mk(OP_MAC, A_S, A_XY, A_OY, A_NONE, K_ONE);
      7'd52: i = mk(OP_MAC, A_S, A_XZ, A_OZ, A_NONE, K_ONE);
      7'd53: i = mk(OP_MUL, A_C, A_XX, A_RX, A_NONE, K_ONE);
      7'd54: i = mk(OP_MAC, A_C, A_XY, A_RY, A_NONE, K_ONE);
      7'd55: i = mk(OP_MAC, A_C, A_XZ, A_RZ, A_NONE, K_ONE);
      7'd56: i = mk(OP_MUL, A_TMP, A_ALPHA, A_RX, A_NONE, K_ONE);
      7'd57: i = mk(OP_MSB, A_TMP, A_BETA, A_P0X, A_NONE, K_ONE);
      7'd58: i = mk(OP_MUL, A_G, A_TMP, A_OX, A_NONE, K_ONE);
      7'd59: i = mk(OP_MUL, A_TMP, A_ALPHA, A_RY, A_NONE, K_ONE);
      7'd60: i = mk(OP_MSB, A_TMP, A_BETA, A_P0Y, A_NONE, K_ONE);
      7'd61: i = mk(OP_MUL, A_TMP, A_TMP, A_OY, A_NONE, K_ONE);
      7'd62: i = mk(OP_ADD, A_G, A_G, A_TMP, A_NONE, K_ONE);
      7'd63: i = mk(OP_MUL, A_TMP, A_ALPHA, A_RZ, A_NONE, K_ONE);
      7'd64: i = mk(OP_MSB, A_TMP, A_BETA, A_P0Z, A_NONE, K_ONE);
      7'd65: i = mk(OP_MUL, A_TMP, A_TMP, A_OZ, A_NONE, K_ONE);
      7'd66: i = mk(OP_ADD, A_G, A_G, A_TMP, A_NONE, K_ONE);
      7'd67: i = mk(OP_LDK, A_K, A_NONE, A_NONE, A_NONE, K_2P16);
      7'd68: i = mk(OP_MULDIV, A_G, A_G, A_K1, A_K, K_ONE);
      7'd69: i = mk(OP_LDK, A_K, A_NONE, A_NONE, A_NONE, K_2P24);
      7'd70: i = mk(OP_MULDIV, A_S, A_S, A_K, A_F, K_ONE);
      7'd71: i = mk(OP_MULDIV, A_C, A_C, A_G, A_F, K_ONE);
      7'd72: i = mk(OP_LDK, A_K, A_NONE, A_NONE, A_NONE, K_2P40);
      7'd73: i = mk(OP_MULDIV, A_G, A_C, A_K, A_F, K_ONE);
      7'd74: i = mk(OP_SATSUB, A_S, A_S, A_G, A_NONE, K_ONE);
      7'd75: i = mk(OP_LDR, A_TMP, A_NONE, A_NONE, A_NONE, W_WEIGHT);
      7'd76: i = mk(OP_LDR, A_ALPHA, A_NONE, A_NONE, A_NONE, W_TURNS);
      7'd77: i = mk(OP_MUL, A_TMP, A_TMP, A_ALPHA, A_NONE, K_ONE);
      7'd78: i = mk(OP_LDK, A_K, A_NONE, A_NONE, A_NONE, K_FRAC);
      7'd79: i = mk(OP_MULDIV, A_S, A_S, A_TMP, A_K, K_ONE);
      7'd80: i = mk(OP_SATACC, A_NONE, A_S, A_NONE, A_NONE, K_ONE);
      default: i = mk(OP_END, A_NONE, A_NONE, A_NONE, A_NONE, K_ONE);
    endcase
    return i;
  endfunction

endpackage

// ----- rtl/core/meg_sphere_lead_field_top.sv -----
`timescale 1ns / 1ps

// Spherical-head MEG lead-field accumulator. Each input item is one coil
// integration point; the dipole comes from the six configuration registers.
// A point whose weight is below 1e-4 in magnitude, or that follows an error
// of the same sensor, skips the program and goes straight to the final
// state. A contributing point runs an 81-step program on one scratch memory
// with a single read port (fetch, operand reads, execute and, where a result
// is stored, write-back for each step, plus an end state when an iterative
// unit runs), a 4-bit-digit shift-add multiplier, a 1-bit restoring divider
// and a 2-bit square root. The item marked last_point puts field_value and
// status in the output register and clears the sum; a new item is taken
// while that result waits.
module meg_sphere_lead_field_top import msl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   point_z,
  input  logic signed [31:0]   coil_dir_x,
  input  logic signed [31:0]   coil_dir_y,
  input  logic signed [31:0]   coil_dir_z,
  input  logic signed [31:0]   point_weight,
  input  logic signed [7:0]    coil_turns,
  input  logic                 last_point,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [47:0]   field_value,
  output logic [1:0]           status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_RDC   = 4'd3;
  localparam logic [3:0] S_LATCH = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_MEND  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DEND  = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_SEND  = 4'd11;
  localparam logic [3:0] S_WB    = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [5:0] MUL_LAST  = 6'd15;
  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  logic [3:0]          state;
  logic [PC_W-1:0]     pc;
  instr_t              ins;

  logic signed [31:0]  cfg_reg [CFG_COUNT];
  logic signed [31:0]  pt_reg [6];
  logic signed [31:0]  weight_reg;
  logic signed [7:0]   turns_reg;
  logic                lp_reg;

  logic [63:0]         scratch [SCR_DEPTH];
  logic [4:0]          raddr;
  logic [63:0]         rdata;
  logic                we;

  logic signed [63:0]  opa, opb, opc, acc, res;
  logic signed [63:0]  field_sum;
  logic [1:0]          err;
  logic [127:0]        p;
  logic [63:0]         mag_a;
  logic                neg;
  logic [5:0]          cnt;
  logic [63:0]         sq_bit;

  logic signed [63:0]  raw_word;
  logic signed [63:0]  prod_s, acc_next;
  logic [67:0]         mul_sum;
  logic [127:0]        mul_p_next, div_p_next, sq_p_next;
  logic [63:0]         div_trial, div_rem;
  logic                div_ge;
  logic [63:0]         sq_t;
  logic [63:0]         quo;
  logic signed [63:0]  emit_value;
  logic                accept, w_big;
  logic                emit;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
    logic signed [63:0] v;
    if (s > 65'(SUM_MAX)) v = SUM_MAX;
    else if (s < 65'(SUM_MIN)) v = SUM_MIN;
    else v = s[63:0];
    return v;
  endfunction

  assign ins      = prog_rom(pc);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign w_big    = (point_weight >= EPS_RAW) || (point_weight <= -EPS_RAW);
  assign we       = (state == S_WB);
  assign emit     = (state == S_FIN) && lp_reg && (!out_valid || !out_stall);

  always_comb begin
    case (state)
      S_RDB:   raddr = ins.b;
      S_RDC:   raddr = ins.c;
      default: raddr = ins.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      scratch[ins.dst] <= res;
    end
    rdata <= scratch[raddr];
  end

  always_comb begin
    case (ins.arg)
      W_PX:     raw_word = 64'(pt_reg[0]);
      W_PY:     raw_word = 64'(pt_reg[1]);
      W_PZ:     raw_word = 64'(pt_reg[2]);
      W_OX:     raw_word = 64'(pt_reg[3]);
      W_OY:     raw_word = 64'(pt_reg[4]);
      W_OZ:     raw_word = 64'(pt_reg[5]);
      W_P0X:    raw_word = 64'(cfg_reg[0]);
      W_P0Y:    raw_word = 64'(cfg_reg[1]);
      W_P0Z:    raw_word = 64'(cfg_reg[2]);
      W_QX:     raw_word = 64'(cfg_reg[3]);
      W_QY:     raw_word = 64'(cfg_reg[4]);
      W_QZ:     raw_word = 64'(cfg_reg[5]);
      W_WEIGHT: raw_word = 64'(weight_reg);
      W_TURNS:  raw_word = 64'(turns_reg);
      default:  raw_word = '0;
    endcase
  end

  // multiply: one 4-bit digit of the multiplier per cycle
  assign mul_sum    = {4'd0, p[127:64]} + mag_a * p[3:0];
  assign mul_p_next = {mul_sum, p[63:4]};
  assign prod_s     = neg ? -$signed(p[63:0]) : $signed(p[63:0]);

  always_comb begin
    case (ins.op)
      OP_MAC:  acc_next = acc + prod_s;
      OP_MSB:  acc_next = acc - prod_s;
      default: acc_next = prod_s;
    endcase
  end

  // divide: restoring, one quotient bit per cycle, remainder in p[127:64]
  assign div_trial  = {p[126:64], p[63]};
  assign div_ge     = p[127] || (div_trial >= 64'(opc));
  assign div_rem    = div_ge ? div_trial - 64'(opc) : div_trial;
  assign div_p_next = {div_rem, p[62:0], div_ge};
  assign quo        = p[63] ? 64'(SUM_MAX) : p[63:0];

  // square root: radicand in p[127:64], root in p[63:0]
  assign sq_t = p[63:0] + sq_bit;
  assign sq_p_next = (p[127:64] >= sq_t) ?
                     {p[127:64] - sq_t, (p[63:0] >> 1) + sq_bit} :
                     {p[127:64], p[63:0] >> 1};

  always_comb begin
    emit_value = (err != ST_OK) ? 64'sd0 : field_sum;
    if (emit_value > OUT_HI) emit_value = OUT_HI;
    if (emit_value < OUT_LO) emit_value = OUT_LO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) cfg_reg[i] <= '0;
    end else if (cfg_write && (cfg_index < CFG_IDX_W'(CFG_COUNT))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      field_sum <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pt_reg[0]  <= point_x;
            pt_reg[1]  <= point_y;
            pt_reg[2]  <= point_z;
            pt_reg[3]  <= coil_dir_x;
            pt_reg[4]  <= coil_dir_y;
            pt_reg[5]  <= coil_dir_z;
            weight_reg <= point_weight;
            turns_reg  <= coil_turns;
            lp_reg     <= last_point;
            pc         <= '0;
            state      <= ((err == ST_OK) && w_big) ? S_FETCH : S_FIN;
          end
        end
        S_FETCH: state <= S_RDB;
        S_RDB: begin
          opa   <= rdata;
          state <= S_RDC;
        end
        S_RDC: begin
          opb   <= rdata;
          state <= S_LATCH;
        end
        S_LATCH: begin
          opc   <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_WB;
          case (ins.op)
            OP_LDW:    res <= to_work(raw_word[31:0]);
            OP_LDR:    res <= raw_word;
            OP_LDK:    res <= kconst(ins.arg);
            OP_ADD:    res <= opa + opb;
            OP_SUB:    res <= opa - opb;
            OP_SATSUB: res <= sat65(65'(opa) - 65'(opb));
            OP_SATACC: begin
              field_sum <= sat65(65'(field_sum) + 65'(opa));
              pc        <= pc + 1'b1;
              state     <= S_FETCH;
            end
            OP_MUL, OP_MAC, OP_MSB, OP_MULDIV: begin
              mag_a <= mag64(opa);
              p     <= {64'd0, mag64(opb)};
              neg   <= opa[63] ^ opb[63];
              cnt   <= '0;
              state <= S_MUL;
            end
            OP_SQRT: begin
              p      <= {opa, 64'd0};
              sq_bit <= 64'd1 << 62;
              cnt    <= '0;
              state  <= S_SQRT;
            end
            OP_CHKZ: begin
              if (opa == 64'sd0) begin
                err   <= ins.arg[1:0];
                state <= S_FIN;
              end else begin
                pc    <= pc + 1'b1;
                state <= S_FETCH;
              end
            end
            OP_CHKP: begin
              if (opa <= 64'sd0) begin
                err   <= ins.arg[1:0];
                state <= S_FIN;
              end else begin
                pc    <= pc + 1'b1;
                state <= S_FETCH;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_MUL: begin
          p   <= mul_p_next;
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) state <= S_MEND;
        end
        S_MEND: begin
          if (ins.op == OP_MULDIV) begin
            if (p[127:64] >= 64'(opc)) begin
              res   <= neg ? -SUM_MAX : SUM_MAX;
              state <= S_WB;
            end else begin
              cnt   <= '0;
              state <= S_DIV;
            end
          end else begin
            acc   <= acc_next;
            res   <= acc_next;
            state <= S_WB;
          end
        end
        S_DIV: begin
          p   <= div_p_next;
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= S_DEND;
        end
        S_DEND: begin
          res   <= neg ? -$signed(quo) : $signed(quo);
          state <= S_WB;
        end
        S_SQRT: begin
          p      <= sq_p_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 1'b1;
          if (cnt == SQRT_LAST) state <= S_SEND;
        end
        S_SEND: begin
          res   <= $signed(p[63:0]);
          state <= S_WB;
        end
        S_WB: begin
          pc    <= pc + 1'b1;
          state <= S_FETCH;
        end
        S_FIN: begin
          if (!lp_reg) begin
            state <= S_IDLE;
          end else if (emit) begin
            field_value <= emit_value[47:0];
            status      <= err;
            field_sum   <= '0;
            err         <= ST_OK;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> field_value == 48'sd0)
    else $error("error result carries a nonzero value");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("item taken while sequencer busy");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK) && (state != S_FIN) |=> err == $past(err))
    else $error("error code changed before emission");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (field_sum == 64'sd0) && (err == ST_OK))
    else $error("sum not cleared after emission");

endmodule
